### sv/hxmap_pkg.sv
// ----------------------------------------------------------------------------
// hxmap_pkg
// Shared constants and types for the hex-grid map trainer: grid geometry,
// request kinds, sequencer states and the datapath control word.
// ----------------------------------------------------------------------------
package hxmap_pkg;

    localparam int GRID_ROWS  = 7;
    localparam int GRID_COLS  = 11;
    localparam int NODE_COUNT = GRID_ROWS * GRID_COLS;
    localparam int NODE_W     = 7;

    localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

    // axial coordinate origin
    localparam int ROW_R_MIN = GRID_ROWS / 2 + 1 - GRID_ROWS;
    localparam int COL_Q_MIN = GRID_COLS / 2 + 1 - GRID_COLS;
    localparam int CRD_W     = 9;

    localparam int RATE_W = 9;
    localparam logic [RATE_W-1:0] RATE_RESET = 9'd230;
    localparam logic [RATE_W-1:0] RATE_ONE   = 9'd256;

    localparam int CH_W = 16;
    localparam int WV_W = 3 * CH_W;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TRAIN = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_wvec;

    typedef struct packed {
        logic              scan;
        logic              upd;
        logic [NODE_W-1:0] idx;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_alu_ctl;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        t_wvec             data;
    } t_wr_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_RDATA,
        ST_SCAN,
        ST_SWAIT,
        ST_UPDATE,
        ST_UWAIT,
        ST_DONE
    } t_state;

endpackage

### sv/hxmap_mem.sv
// ----------------------------------------------------------------------------
// hxmap_mem
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hxmap_mem #(
    parameter int AW    = 7,
    parameter int DW    = 48,
    parameter int DEPTH = 77
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/hxmap_alu.sv
// ----------------------------------------------------------------------------
// hxmap_alu
// Per-node datapath shared by the scan and update passes. Stage 1 forms
// the sample-minus-weight differences and one multiply per channel (square
// while scanning, times rate while updating) plus the hex distance to the
// winner. Stage 2 either accumulates and compares the distance, or shifts,
// adds and clamps the new weight for write-back.
// ----------------------------------------------------------------------------
module hxmap_alu (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hxmap_pkg::t_alu_ctl            i_ctl,
    input  hxmap_pkg::t_wvec               i_rdata,
    input  hxmap_pkg::t_wvec               i_sample,
    input  logic [hxmap_pkg::RATE_W-1:0]   i_rate,
    output hxmap_pkg::t_wr_req             o_wr,
    output logic [hxmap_pkg::NODE_W-1:0]   o_bmu
);
    import hxmap_pkg::*;

    localparam int DIFF_W = 18;
    localparam int MUL_W  = 2 * DIFF_W;
    localparam int SH_W   = 6;
    localparam int SH_MAX = MUL_W - 1;
    localparam int SUM_W  = 34;
    localparam int NW_W   = CH_W + 3;

    function automatic logic [CRD_W-1:0] hex_dist(
        input logic [COL_W-1:0] col_a,
        input logic [ROW_W-1:0] row_a,
        input logic [COL_W-1:0] col_b,
        input logic [ROW_W-1:0] row_b
    );
        logic signed [CRD_W-1:0] qa, qb, ra, rb, dq, dr, ds, aq, ar, as_, m;
        qa = $signed(CRD_W'(COL_Q_MIN)) + $signed({{(CRD_W-COL_W){1'b0}}, col_a});
        qb = $signed(CRD_W'(COL_Q_MIN)) + $signed({{(CRD_W-COL_W){1'b0}}, col_b});
        ra = $signed(CRD_W'(ROW_R_MIN)) - (qa >>> 1)
             + $signed({{(CRD_W-ROW_W){1'b0}}, row_a});
        rb = $signed(CRD_W'(ROW_R_MIN)) - (qb >>> 1)
             + $signed({{(CRD_W-ROW_W){1'b0}}, row_b});
        dq  = qa - qb;
        dr  = ra - rb;
        ds  = -dq - dr;
        aq  = (dq < 0) ? -dq : dq;
        ar  = (dr < 0) ? -dr : dr;
        as_ = (ds < 0) ? -ds : ds;
        m   = aq;
        if (ar > m) m = ar;
        if (as_ > m) m = as_;
        return m;
    endfunction

    t_alu_ctl r1_ctl, r2_ctl;

    // winner tracking
    logic [SUM_W-1:0]  r_best;
    logic [NODE_W-1:0] r_best_idx;
    logic [ROW_W-1:0]  r_best_row;
    logic [COL_W-1:0]  r_best_col;

    logic signed [DIFF_W-1:0] w_diff [3];
    logic signed [DIFF_W-1:0] w_opb  [3];
    logic signed [MUL_W-1:0]  w_prod [3];
    logic [CH_W-1:0]          w_w    [3];
    logic [CH_W-1:0]          w_s    [3];
    logic [CRD_W-1:0]         w_dist;

    logic signed [MUL_W-1:0]  r2_mul [3];
    logic [CH_W-1:0]          r2_w   [3];
    logic [SH_W-1:0]          r2_sh;

    logic [SUM_W-1:0]         w_sum;
    logic signed [MUL_W-1:0]  w_step [3];
    logic signed [NW_W-1:0]   w_nw   [3];
    logic [CH_W-1:0]          w_new  [3];

    assign w_w[0] = i_rdata.red;
    assign w_w[1] = i_rdata.green;
    assign w_w[2] = i_rdata.blue;
    assign w_s[0] = i_sample.red;
    assign w_s[1] = i_sample.green;
    assign w_s[2] = i_sample.blue;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_diff[c] = $signed({2'b00, w_s[c]}) - $signed({2'b00, w_w[c]});
            w_opb[c]  = r1_ctl.scan ? w_diff[c]
                                    : $signed({{(DIFF_W-RATE_W){1'b0}}, i_rate});
            w_prod[c] = w_diff[c] * w_opb[c];
        end
    end

    assign w_dist = hex_dist(r1_ctl.col, r1_ctl.row, r_best_col, r_best_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r2_mul[c] <= w_prod[c];
            r2_w[c]   <= w_w[c];
        end
        if (w_dist > CRD_W'(SH_MAX - 8)) begin
            r2_sh <= SH_W'(SH_MAX);
        end else begin
            r2_sh <= SH_W'(w_dist) + SH_W'(8);
        end
    end

    // stage 2: distance accumulate and compare, lowest index wins ties
    assign w_sum = {2'b00, r2_mul[0][31:0]} + {2'b00, r2_mul[1][31:0]}
                 + {2'b00, r2_mul[2][31:0]};

    always_ff @(posedge i_clk) begin
        if (r2_ctl.scan && (r2_ctl.idx == '0 || w_sum < r_best)) begin
            r_best     <= w_sum;
            r_best_idx <= r2_ctl.idx;
            r_best_row <= r2_ctl.row;
            r_best_col <= r2_ctl.col;
        end
    end

    // stage 2: floored step, clamped to the weight range
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_step[c] = r2_mul[c] >>> r2_sh;
            w_nw[c]   = $signed({3'b000, r2_w[c]}) + $signed(w_step[c][NW_W-1:0]);
            if (w_nw[c] < 0) begin
                w_new[c] = '0;
            end else if (w_nw[c] > $signed(NW_W'(65535))) begin
                w_new[c] = '1;
            end else begin
                w_new[c] = w_nw[c][CH_W-1:0];
            end
        end
    end

    assign o_wr.en         = r2_ctl.upd;
    assign o_wr.addr       = r2_ctl.idx;
    assign o_wr.data.red   = w_new[0];
    assign o_wr.data.green = w_new[1];
    assign o_wr.data.blue  = w_new[2];
    assign o_bmu           = r_best_idx;

endmodule

### sv/hex_som_train_step.sv
// ----------------------------------------------------------------------------
// hex_som_train_step
// States: write WRITE, DONE; read READ, RDATA, DONE; train SCAN, SWAIT, UPDATE, UWAIT, DONE.
// Throughput: one request at a time; a train request makes one pass of the
// shared node datapath over all nodes to find the winner and a second pass to
// update them, one node per cycle through the weight RAM read and write ports.
// Reset: synchronous active-low; clears control and sets the rate to 230.
// Node weights are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module hex_som_train_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hxmap_pkg::RATE_W-1:0]  i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_kind,
    input  logic [hxmap_pkg::NODE_W-1:0]  i_node_index,
    input  logic [7:0]                    i_sample_red,
    input  logic [7:0]                    i_sample_green,
    input  logic [7:0]                    i_sample_blue,
    input  logic [hxmap_pkg::CH_W-1:0]    i_load_red,
    input  logic [hxmap_pkg::CH_W-1:0]    i_load_green,
    input  logic [hxmap_pkg::CH_W-1:0]    i_load_blue,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hxmap_pkg::NODE_W-1:0]  o_result_node,
    output logic [hxmap_pkg::CH_W-1:0]    o_weight_red,
    output logic [hxmap_pkg::CH_W-1:0]    o_weight_green,
    output logic [hxmap_pkg::CH_W-1:0]    o_weight_blue
);
    import hxmap_pkg::*;

    t_state r_state, n_state;

    logic [RATE_W-1:0] r_rate;
    logic [RATE_W-1:0] w_rate_sat;

    logic [NODE_W-1:0] r_node;
    t_wvec             r_sample;
    t_wvec             r_load;
    logic              w_in_range;

    logic [NODE_W-1:0] r_idx, n_idx;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_wait, n_wait;
    logic              w_last;

    t_wvec             r_tw, n_tw;
    logic [NODE_W-1:0] r_tnode, n_tnode;

    logic              r_ovalid, n_ovalid;
    logic [NODE_W-1:0] r_onode, n_onode;
    t_wvec             r_ow, n_ow;

    t_alu_ctl          w_ctl;
    t_wr_req           w_alu_wr;
    logic [NODE_W-1:0] w_bmu;
    logic [NODE_W-1:0] w_raddr;
    t_wvec             w_rdata;
    logic              w_we;
    logic [NODE_W-1:0] w_waddr;
    t_wvec             w_wdata;
    logic              w_accept;

    assign w_accept   = i_valid && !o_stall;
    assign o_stall    = (r_state != ST_IDLE);
    assign w_rate_sat = (r_rate > RATE_ONE) ? RATE_ONE : r_rate;
    assign w_in_range = (r_node < NODE_W'(NODE_COUNT));
    assign w_last     = (r_idx == NODE_W'(NODE_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_rate <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_node         <= i_node_index;
            r_sample.red   <= {i_sample_red, 8'h00};
            r_sample.green <= {i_sample_green, 8'h00};
            r_sample.blue  <= {i_sample_blue, 8'h00};
            r_load.red     <= i_load_red;
            r_load.green   <= i_load_green;
            r_load.blue    <= i_load_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_row   <= n_row;
        r_col   <= n_col;
        r_wait  <= n_wait;
        r_tw    <= n_tw;
        r_tnode <= n_tnode;
        r_onode <= n_onode;
        r_ow    <= n_ow;
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_row    = r_row;
        n_col    = r_col;
        n_wait   = r_wait;
        n_tw     = r_tw;
        n_tnode  = r_tnode;
        n_ovalid = r_ovalid && i_stall;
        n_onode  = r_onode;
        n_ow     = r_ow;
        w_ctl    = '0;
        w_raddr  = r_idx;
        w_we     = 1'b0;
        w_waddr  = r_node;
        w_wdata  = r_load;

        // node counter walks column by column
        if (r_state == ST_SCAN || r_state == ST_UPDATE) begin
            n_idx = r_idx + NODE_W'(1);
            if (r_row == ROW_W'(GRID_ROWS - 1)) begin
                n_row = '0;
                n_col = r_col + COL_W'(1);
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end

        // keep the winner's updated weights as they are written back
        if (w_alu_wr.en && w_alu_wr.addr == w_bmu) begin
            n_tw = w_alu_wr.data;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_idx = '0;
                    n_row = '0;
                    n_col = '0;
                    case (i_kind)
                        KIND_WRITE: n_state = ST_WRITE;
                        KIND_TRAIN: n_state = ST_SCAN;
                        default:    n_state = ST_READ;
                    endcase
                end
            end
            ST_WRITE: begin
                w_we    = w_in_range;
                n_tw    = w_in_range ? r_load : '0;
                n_tnode = r_node;
                n_state = ST_DONE;
            end
            ST_READ: begin
                w_raddr = r_node;
                n_state = ST_RDATA;
            end
            ST_RDATA: begin
                n_tw    = w_in_range ? w_rdata : '0;
                n_tnode = r_node;
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                w_ctl.scan = 1'b1;
                w_ctl.idx  = r_idx;
                w_ctl.row  = r_row;
                w_ctl.col  = r_col;
                if (w_last) begin
                    n_idx   = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = ST_SWAIT;
                end
            end
            ST_SWAIT: begin
                // last compare lands before the first distance is taken
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                w_ctl.upd = 1'b1;
                w_ctl.idx = r_idx;
                w_ctl.row = r_row;
                w_ctl.col = r_col;
                if (w_last) begin
                    n_wait  = 1'b0;
                    n_state = ST_UWAIT;
                end
            end
            ST_UWAIT: begin
                n_wait = 1'b1;
                if (r_wait) begin
                    n_tnode = w_bmu;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_onode  = r_tnode;
                    n_ow     = r_tw;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_alu_wr.en) begin
            w_we    = 1'b1;
            w_waddr = w_alu_wr.addr;
            w_wdata = w_alu_wr.data;
        end
    end

    hxmap_mem #(
        .AW    (NODE_W),
        .DW    (WV_W),
        .DEPTH (NODE_COUNT)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hxmap_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_rdata  (w_rdata),
        .i_sample (r_sample),
        .i_rate   (w_rate_sat),
        .o_wr     (w_alu_wr),
        .o_bmu    (w_bmu)
    );

    assign o_valid        = r_ovalid;
    assign o_result_node  = r_onode;
    assign o_weight_red   = r_ow.red;
    assign o_weight_green = r_ow.green;
    assign o_weight_blue  = r_ow.blue;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("request accepted but block not busy");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside the done state");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_WRITE || r_state == ST_UPDATE || r_state == ST_UWAIT))
        else $error("weight RAM written outside a write or update phase");

    a_update_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && $past(r_state) != ST_UPDATE) |-> $past(r_state == ST_SWAIT))
        else $error("update pass started without a finished scan");

    a_kind_write_no_alu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> !w_alu_wr.en)
        else $error("RAM write port claimed twice");

endmodule
